FILE: rtl/kplc_pkg.sv
package kplc_pkg;

  // Alphabet and character codes.
  localparam int unsigned ALPHA = 26;
  localparam logic [7:0] CHAR_A = 8'd97;
  localparam logic [7:0] CHAR_Z = 8'd122;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  // Key store geometry.
  localparam int unsigned KEY_MAX = 24;
  localparam int unsigned KEY_HALF = 12;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned KEY_WORD_W = KEY_HALF * LETTER_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = KEY_WORD_W;
  localparam logic [CFG_IDX_W-1:0] REG_KEYED_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_DIR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd5;

  // Queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_SPACE,
    KIND_LETTER,
    KIND_BAD
  } kplc_kind_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_message;
  } kplc_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       bad_char;
    logic       last_out;
  } kplc_out_t;

  typedef struct packed {
    logic                  keyed_mode;
    logic                  decode_dir;
    logic [LETTER_W-1:0]   base_shift;
    logic [LETTER_W-1:0]   key_length;
    logic [KEY_WORD_W-1:0] key_low;
    logic [KEY_WORD_W-1:0] key_high;
  } kplc_cfg_t;

  // One classified character on its way to the back end. The shift is
  // already folded for direction, so the back end always adds.
  typedef struct packed {
    kplc_kind_e          kind;
    logic [LETTER_W-1:0] letter;
    logic [LETTER_W-1:0] shift;
    logic                last;
  } kplc_job_t;

  // Reduce a 5-bit value modulo 26.
  function automatic logic [LETTER_W-1:0] mod_alpha(input logic [LETTER_W-1:0] v);
    logic [LETTER_W-1:0] r;
    r = (v >= LETTER_W'(ALPHA)) ? v - LETTER_W'(ALPHA) : v;
    return r;
  endfunction

endpackage

FILE: rtl/kplc_front.sv
module kplc_front import kplc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  kplc_cfg_t cfg_i,
  input  logic      accept_i,
  input  kplc_in_t  in_data_i,
  output kplc_job_t job_o
);

  logic [LETTER_W-1:0] pos_q, pos_d;
  logic [LETTER_W-1:0] kidx_q, kidx_d;
  logic [LETTER_W-1:0] len, idx, key_val, total;
  logic [LETTER_W-1:0] keys [KEY_MAX];
  logic [6:0]          sum;

  // Unpack the key words into letters.
  always_comb begin
    for (int k = 0; k < KEY_HALF; k++) begin
      keys[k]            = cfg_i.key_low[k*LETTER_W +: LETTER_W];
      keys[k + KEY_HALF] = cfg_i.key_high[k*LETTER_W +: LETTER_W];
    end
  end

  // Effective key length and the key slot in use.
  always_comb begin
    if (cfg_i.key_length == '0) begin
      len = LETTER_W'(1);
    end else if (cfg_i.key_length > LETTER_W'(KEY_MAX)) begin
      len = LETTER_W'(KEY_MAX);
    end else begin
      len = cfg_i.key_length;
    end
    idx = (kidx_q < len) ? kidx_q : '0;
    key_val = mod_alpha(keys[idx]);
  end

  // Total shift modulo 26, folded for decode when the job is built.
  always_comb begin
    sum = 7'(mod_alpha(cfg_i.base_shift));
    if (cfg_i.keyed_mode) begin
      sum = sum + 7'(pos_q) + 7'(key_val);
    end
    priority if (sum >= 7'(2 * ALPHA)) begin
      total = LETTER_W'(sum - 7'(2 * ALPHA));
    end else if (sum >= 7'(ALPHA)) begin
      total = LETTER_W'(sum - 7'(ALPHA));
    end else begin
      total = LETTER_W'(sum);
    end
  end

  // Classify the character and build the job.
  always_comb begin
    job_o.last   = in_data_i.end_of_message;
    job_o.letter = LETTER_W'(in_data_i.char_code - CHAR_A);
    if (cfg_i.decode_dir && total != '0) begin
      job_o.shift = LETTER_W'(ALPHA) - total;
    end else begin
      job_o.shift = total;
    end
    priority if (in_data_i.char_code == CHAR_SPACE) begin
      job_o.kind = KIND_SPACE;
    end else if (in_data_i.char_code >= CHAR_A && in_data_i.char_code <= CHAR_Z) begin
      job_o.kind = KIND_LETTER;
    end else begin
      job_o.kind = KIND_BAD;
    end
  end

  // Position counters advance on every transfer and clear after the last one.
  always_comb begin
    pos_d  = pos_q;
    kidx_d = kidx_q;
    if (accept_i) begin
      if (in_data_i.end_of_message) begin
        pos_d  = '0;
        kidx_d = '0;
      end else begin
        pos_d  = (pos_q == LETTER_W'(ALPHA - 1)) ? '0 : pos_q + LETTER_W'(1);
        kidx_d = (idx + LETTER_W'(1) >= len) ? '0 : idx + LETTER_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kidx_q <= '0;
    end else begin
      pos_q  <= pos_d;
      kidx_q <= kidx_d;
    end
  end

  // The counters stay inside their ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q < LETTER_W'(ALPHA))
    else $error("position counter out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) kidx_q < LETTER_W'(KEY_MAX))
    else $error("key index out of range");

endmodule

FILE: rtl/kplc_queue.sv
module kplc_queue import kplc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  kplc_job_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output kplc_job_t data_o
);

  kplc_job_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    n = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    return n;
  endfunction

  // Storage takes no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // Fill count tracks transfers in and out.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + QCNT_W'(1))
    else $error("queue count missed a push");

endmodule

FILE: rtl/kplc_back.sv
module kplc_back import kplc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  kplc_job_t job_i,
  output logic      job_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output kplc_out_t out_data_o
);

  logic                out_valid_q, out_valid_d;
  kplc_out_t           out_q, out_d;
  logic [LETTER_W:0]   lsum;
  logic [LETTER_W-1:0] lres;

  // Take a job whenever the output register is free or being drained.
  assign job_pop_o = job_valid_i && (!out_valid_q || pop_i);

  // Apply the shift to the letter, modulo 26.
  always_comb begin
    lsum = (LETTER_W+1)'(job_i.letter) + (LETTER_W+1)'(job_i.shift);
    lres = (lsum >= (LETTER_W+1)'(ALPHA)) ? LETTER_W'(lsum - (LETTER_W+1)'(ALPHA))
                                          : LETTER_W'(lsum);
  end

  // Form the result.
  always_comb begin
    out_d.last_out = job_i.last;
    unique case (job_i.kind)
      KIND_SPACE: begin
        out_d.out_char = CHAR_SPACE;
        out_d.bad_char = 1'b0;
      end
      KIND_LETTER: begin
        out_d.out_char = CHAR_A + 8'(lres);
        out_d.bad_char = 1'b0;
      end
      default: begin
        out_d.out_char = '0;
        out_d.bad_char = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (job_pop_o) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      out_q <= out_d;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

  // A shifted letter stays in the alphabet; an error result is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.bad_char && out_q.out_char != CHAR_SPACE)
      |-> (out_q.out_char >= CHAR_A && out_q.out_char <= CHAR_Z))
    else $error("shifted letter left the alphabet");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.bad_char) |-> out_q.out_char == '0)
    else $error("error result not zero");

endmodule

FILE: rtl/keyed_progressive_letter_cipher.sv
// Keyed progressive letter cipher. One ASCII character is pushed per transfer
// and one result comes out per character, in order. Spaces pass unchanged,
// lowercase letters are shifted modulo 26 (Caesar or keyed progressive, encode
// or decode), anything else gives 0 with bad_char set. The block sustains one
// character per clock cycle unless it stalls on a full queue or a held pop; an
// accepted character passes through a two-entry queue between the classifier
// and the shifter, then one output register. Write configuration only
// while no result is outstanding. Position and key counters restart after a
// character marked as the end of a message.
module keyed_progressive_letter_cipher import kplc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  kplc_in_t              in_data_i,
  output logic                  empty,
  input  logic                  pop,
  output kplc_out_t             out_data_o
);

  kplc_cfg_t cfg_q;
  kplc_job_t front_job, back_job;
  logic      accept, job_valid, job_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{keyed_mode: 1'b0, decode_dir: 1'b0, base_shift: '0,
                 key_length: LETTER_W'(1), key_low: '0, key_high: '0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEYED_MODE: cfg_q.keyed_mode <= cfg_data_i[0];
        REG_DECODE_DIR: cfg_q.decode_dir <= cfg_data_i[0];
        REG_BASE_SHIFT: cfg_q.base_shift <= cfg_data_i[LETTER_W-1:0];
        REG_KEY_LENGTH: cfg_q.key_length <= cfg_data_i[LETTER_W-1:0];
        REG_KEY_LOW:    cfg_q.key_low    <= cfg_data_i[KEY_WORD_W-1:0];
        REG_KEY_HIGH:   cfg_q.key_high   <= cfg_data_i[KEY_WORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  // Front end: classify and compute the shift.
  kplc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .job_o     (front_job)
  );

  // Decoupling queue.
  kplc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (back_job)
  );

  // Back end: apply the shift and hold the result.
  kplc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (back_job),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/tb_keyed_progressive_letter_cipher.sv
`timescale 1ns / 1ps

module tb_keyed_progressive_letter_cipher;
  import kplc_pkg::*;

  localparam int unsigned CLK_HALF = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASES = 16;
  localparam int unsigned PHASE_ITEMS = 85;
  localparam int unsigned REPORT_MAX = 10;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push = 1'b0;
  logic                  full;
  kplc_in_t              in_data_i = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  kplc_out_t             out_data_o;

  // Shadow copy of the configuration registers.
  logic                  keyed_q = 1'b0;
  logic                  decode_q = 1'b0;
  logic [LETTER_W-1:0]   shift_q = '0;
  logic [LETTER_W-1:0]   klen_q = LETTER_W'(1);
  logic [KEY_WORD_W-1:0] key_low_q = '0;
  logic [KEY_WORD_W-1:0] key_high_q = '0;

  // Shadow copy of the message position counters.
  logic [LETTER_W-1:0]   pos_q = '0;
  logic [LETTER_W-1:0]   kidx_q = '0;

  kplc_in_t  char_backlog[$];
  kplc_out_t due_chars[$];

  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic rx_hold = 1'b0;
  logic hold_start = 1'b0;
  int   hold_cnt = 0;
  int   errors = 0;
  int   cycles = 0;

  keyed_progressive_letter_cipher uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  // Free-running clock.
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Key letter k from the two key words, folded into the alphabet.
  function automatic int key_letter_at(int k);
    logic [LETTER_W-1:0] v;
    if (k < KEY_HALF) v = key_low_q[k*LETTER_W +: LETTER_W];
    else v = key_high_q[(k-KEY_HALF)*LETTER_W +: LETTER_W];
    return int'(v) % ALPHA;
  endfunction

  // Cipher one character and advance the position counters.
  function automatic kplc_out_t cipher_step(kplc_in_t din);
    kplc_out_t r;
    int len;
    int idx;
    int total;
    int letter;
    len = (klen_q == 0) ? 1 : ((klen_q > KEY_MAX) ? KEY_MAX : int'(klen_q));
    idx = (int'(kidx_q) < len) ? int'(kidx_q) : 0;
    r.bad_char = 1'b0;
    r.last_out = din.end_of_message;
    if (din.char_code == CHAR_SPACE) begin
      r.out_char = CHAR_SPACE;
    end else if (din.char_code >= CHAR_A && din.char_code <= CHAR_Z) begin
      total = int'(shift_q) % ALPHA;
      if (keyed_q) total = total + int'(pos_q) % ALPHA + key_letter_at(idx);
      total = total % ALPHA;
      letter = int'(din.char_code - CHAR_A);
      if (decode_q) letter = (letter + ALPHA - total) % ALPHA;
      else letter = (letter + total) % ALPHA;
      r.out_char = CHAR_A + 8'(letter);
    end else begin
      r.out_char = '0;
      r.bad_char = 1'b1;
    end
    if (din.end_of_message) begin
      pos_q = '0;
      kidx_q = '0;
    end else begin
      pos_q = LETTER_W'((int'(pos_q) + 1) % ALPHA);
      kidx_q = (idx + 1 >= len) ? '0 : LETTER_W'(idx + 1);
    end
    return r;
  endfunction

  function automatic kplc_in_t mk_char(logic [7:0] c, logic last);
    kplc_in_t d;
    d.char_code = c;
    d.end_of_message = last;
    return d;
  endfunction

  // Appends one character to the pending list.
  function automatic void add_char(logic [7:0] c, logic last);
    char_backlog.insert(char_backlog.size(), mk_char(c, last));
  endfunction

  // Driver: offers the oldest pending character and predicts each transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        due_chars.insert(due_chars.size(), cipher_step(in_data_i));
        void'(char_backlog.pop_front());
      end
      // A stalled offer stays on the port unchanged.
      if (!(push && full)) begin
        if (char_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          push <= 1'b1;
          in_data_i <= char_backlog[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    kplc_out_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (due_chars.size() == 0) begin
          if (errors < REPORT_MAX)
            $display("unexpected result: char %h bad %b last %b",
                     out_data_o.out_char, out_data_o.bad_char, out_data_o.last_out);
          errors++;
        end else begin
          want = due_chars.pop_front();
          if (out_data_o !== want) begin
            if (errors < REPORT_MAX)
              $display("mismatch: expected char %h bad %b last %b, got char %h bad %b last %b",
                       want.out_char, want.bad_char, want.last_out,
                       out_data_o.out_char, out_data_o.bad_char, out_data_o.last_out);
            errors++;
          end
        end
      end
      pop <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Receiver hold-off: counts its own cycles once started.
  always @(posedge clk_i) begin
    if (hold_start) begin
      rx_hold <= 1'b1;
      hold_cnt <= 0;
    end else if (rx_hold) begin
      if (hold_cnt == HOLD_CYCLES - 1) rx_hold <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_KEYED_MODE: keyed_q = val[0];
      REG_DECODE_DIR: decode_q = val[0];
      REG_BASE_SHIFT: shift_q = val[LETTER_W-1:0];
      REG_KEY_LENGTH: klen_q = val[LETTER_W-1:0];
      REG_KEY_LOW:    key_low_q = val[KEY_WORD_W-1:0];
      REG_KEY_HIGH:   key_high_q = val[KEY_WORD_W-1:0];
      default: ;
    endcase
  endtask

  // Writes all six registers; only called while the block is idle.
  task automatic apply_settings(logic m, logic d, logic [LETTER_W-1:0] s,
                                logic [LETTER_W-1:0] l, logic [KEY_WORD_W-1:0] lo,
                                logic [KEY_WORD_W-1:0] hi);
    write_reg(REG_KEYED_MODE, CFG_DATA_W'(m));
    write_reg(REG_DECODE_DIR, CFG_DATA_W'(d));
    write_reg(REG_BASE_SHIFT, CFG_DATA_W'(s));
    write_reg(REG_KEY_LENGTH, CFG_DATA_W'(l));
    write_reg(REG_KEY_LOW, CFG_DATA_W'(lo));
    write_reg(REG_KEY_HIGH, CFG_DATA_W'(hi));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every character is sent and every result is back.
  task automatic drain();
    while (char_backlog.size() != 0 || due_chars.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One message: mostly letters and spaces, some noise bytes, usually ended.
  task automatic queue_message(int max_len);
    int n;
    int pick;
    logic [7:0] c;
    logic last;
    n = $urandom_range(max_len, 1);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      last = (i == n - 1) && ($urandom_range(7) != 0);
      if (pick < 72) begin
        c = CHAR_A + 8'($urandom_range(ALPHA - 1));
      end else if (pick < 87) begin
        c = CHAR_SPACE;
      end else begin
        c = 8'($urandom);
        if (pick >= 97) last = 1'($urandom_range(1));
      end
      add_char(c, last);
    end
  endtask

  initial begin
    logic [7:0] edge_codes[9];
    edge_codes = '{CHAR_A, CHAR_Z, CHAR_SPACE, 8'h00, 8'hFF, 8'h60, 8'h7B, 8'h1F, 8'h21};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Character class boundaries under the reset configuration.
    foreach (edge_codes[i]) add_char(edge_codes[i], i == 8);
    drain();

    // Shift and key values above 25, key length above the maximum.
    apply_settings(1'b1, 1'b0, 5'd31, 5'd31, '1, '1);
    for (int i = 0; i < 8; i++) add_char(CHAR_Z - 8'(i), 1'b0);
    drain();

    // Key length cut below the running key index mid-message, in decode.
    apply_settings(1'b1, 1'b1, 5'd25, 5'd3, CFG_DATA_W'(60'h0123456789ABCDE), '0);
    add_char(CHAR_A, 1'b0);
    add_char(CHAR_A + 8'd1, 1'b0);
    add_char(CHAR_SPACE, 1'b0);
    add_char(CHAR_A + 8'd16, 1'b1);
    drain();

    // Caesar decode with a key length of zero.
    apply_settings(1'b0, 1'b1, 5'd1, 5'd0, '0, '1);
    add_char(CHAR_A, 1'b0);
    add_char(CHAR_Z, 1'b1);
    drain();

    // Receiver holds off while the sender keeps offering, so the block fills.
    apply_settings(1'b1, 1'b0, 5'd7, 5'd24, KEY_WORD_W'({$urandom, $urandom}),
                   KEY_WORD_W'({$urandom, $urandom}));
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_start <= 1'b1;
    while (char_backlog.size() < 40) queue_message(30);
    @(posedge clk_i);
    hold_start <= 1'b0;
    @(posedge clk_i);
    while (rx_hold) @(posedge clk_i);
    drain();

    // Phases of random messages, each with its own settings and one of four idling patterns.
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      if (p == 0) apply_settings(1'b1, 1'b0, 5'd0, 5'd1, '0, '0);
      else if (p == 1) apply_settings(1'b1, 1'b1, 5'd31, 5'd31, '1, '1);
      else if (p == 2)
        apply_settings(1'b1, 1'b0, 5'd25, 5'd24, KEY_WORD_W'({$urandom, $urandom}),
                       KEY_WORD_W'({$urandom, $urandom}));
      else
        apply_settings($urandom_range(3) != 0, 1'($urandom_range(1)),
                       5'($urandom_range(31)), 5'($urandom_range(31)),
                       KEY_WORD_W'({$urandom, $urandom}),
                       KEY_WORD_W'({$urandom, $urandom}));
      while (char_backlog.size() < PHASE_ITEMS) queue_message(40);
      drain();
    end

    if (errors == 0 && due_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/kplc_pkg.sv
rtl/kplc_front.sv
rtl/kplc_queue.sv
rtl/kplc_back.sv
rtl/keyed_progressive_letter_cipher.sv
tb/tb_keyed_progressive_letter_cipher.sv
